### rtl/core/mptf_pkg.sv
// Shared types, codes and defaults for the multi-pipe ring FIFO table.
// Holds the beat layouts, command kinds, status codes and the result builder.
// No dependencies.
package mptf_pkg;

    // Default sizes for the top-level parameters
    localparam int NUM_PIPES_DEF  = 8;
    localparam int PIPE_DEPTH_DEF = 16;
    localparam int NUM_TASKS_DEF  = 16;

    // Fixed field widths
    localparam int TASK_W = 4;
    localparam int PID_W  = 3;
    localparam int BYTE_W = 8;
    localparam int POUT_W = 4;

    typedef enum logic [1:0] {
        KIND_OPEN,
        KIND_CLOSE,
        KIND_READ,
        KIND_WRITE
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE,
        STAT_REFUSED,
        STAT_IGNORED,
        STAT_BLOCK
    } stat_t;

    // Input beat payload, last field in the lowest bits
    typedef struct packed {
        logic [BYTE_W-1:0] data_in;
        logic [TASK_W-1:0] current_task;
        logic              reader_exists;
        logic              writer_exists;
        logic [TASK_W-1:0] reader_task;
        logic [TASK_W-1:0] writer_task;
        logic [PID_W-1:0]  pipe_id;
    } item_t;

    // Result beat payload, last field in the lowest bits
    typedef struct packed {
        logic [TASK_W-1:0] wake_task;
        logic              wake_valid;
        logic [BYTE_W-1:0] data_out;
        logic [POUT_W-1:0] pipe_out;
        stat_t             status;
    } res_t;

    // Open/close request to the allocation table
    typedef struct packed {
        logic              open_en;
        logic              close_en;
        logic [TASK_W-1:0] writer_task;
        logic [TASK_W-1:0] reader_task;
        logic              writer_exists;
        logic              reader_exists;
    } alloc_cmd_t;

    function automatic res_t make_res(
        input stat_t             status,
        input logic [POUT_W-1:0] pipe_out,
        input logic [BYTE_W-1:0] data_out,
        input logic              wake_valid,
        input logic [TASK_W-1:0] wake_task
    );
        res_t r;
        r.status     = status;
        r.pipe_out   = pipe_out;
        r.data_out   = data_out;
        r.wake_valid = wake_valid;
        r.wake_task  = wake_valid ? wake_task : '0;
        return r;
    endfunction

endpackage

### rtl/core/mptf_alloc.sv
// Pipe allocation table: in-use flags and writer/reader owner pairs.
// Finds duplicate pairs and the lowest free pipe for open; frees on close.
// Depends on mptf_pkg.
module mptf_alloc
    import mptf_pkg::*;
#(
    parameter int NUM_PIPES = NUM_PIPES_DEF,
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int PIPE_W    = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  alloc_cmd_t           cmd,
    input  logic [PIPE_W-1:0]    close_idx,
    output logic                 open_ok,
    output logic [PIPE_W-1:0]    grant_idx,
    output logic [NUM_PIPES-1:0] in_use
);

    logic [NUM_PIPES-1:0] in_use_reg;
    logic [NUM_PIPES-1:0] in_use_next;
    logic [TASK_W-1:0]    own_w_reg [NUM_PIPES];
    logic [TASK_W-1:0]    own_r_reg [NUM_PIPES];
    logic                 dup;
    logic                 free_any;
    logic                 tasks_ok;

    // Scan all pipes for a matching open pair and the lowest free slot
    always_comb
    begin
        dup       = 1'b0;
        free_any  = 1'b0;
        grant_idx = '0;
        for (int p = NUM_PIPES - 1; p >= 0; p--)
        begin
            if (!in_use_reg[p])
            begin
                free_any  = 1'b1;
                grant_idx = PIPE_W'(p);
            end
            if (in_use_reg[p] && own_w_reg[p] == cmd.writer_task
                && own_r_reg[p] == cmd.reader_task)
            begin
                dup = 1'b1;
            end
        end
    end

    assign tasks_ok = cmd.writer_exists && cmd.reader_exists
                      && (32'(cmd.writer_task) < NUM_TASKS)
                      && (32'(cmd.reader_task) < NUM_TASKS);
    assign open_ok  = tasks_ok && !dup && free_any;
    assign in_use   = in_use_reg;

    // Mark granted pipe busy, drop closed pipe
    always_comb
    begin
        in_use_next = in_use_reg;
        if (cmd.open_en && open_ok)
        begin
            in_use_next[grant_idx] = 1'b1;
        end
        if (cmd.close_en)
        begin
            in_use_next[close_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else
        begin
            in_use_reg <= in_use_next;
        end
    end

    // Record owners of a newly granted pipe
    always_ff @(posedge clk)
    begin
        if (cmd.open_en && open_ok)
        begin
            own_w_reg[grant_idx] <= cmd.writer_task;
            own_r_reg[grant_idx] <= cmd.reader_task;
        end
    end

endmodule

### rtl/core/mptf_ring.sv
// Ring byte store shared by all pipes, one region of PIPE_DEPTH bytes per pipe.
// Single port, registered read. Depends on mptf_pkg.
module mptf_ring
    import mptf_pkg::*;
#(
    parameter int NUM_PIPES  = NUM_PIPES_DEF,
    parameter int PIPE_DEPTH = PIPE_DEPTH_DEF,
    parameter int PIPE_W     = 3,
    parameter int PTR_W      = 4
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic              wr_en,
    input  logic [PIPE_W-1:0] pipe,
    input  logic [PTR_W-1:0]  ptr,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    localparam int WORDS  = NUM_PIPES * PIPE_DEPTH;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [BYTE_W-1:0] mem [WORDS];
    logic [BYTE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] addr;

    // Form the flat address from pipe region and ring position
    assign addr = ADDR_W'(32'(pipe) * PIPE_DEPTH + 32'(ptr));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/multi_pipe_ring_fifo_table.sv
// Multi-pipe ring FIFO table: open, close, read-byte and write-byte commands.
// Each item is registered with its descriptor read, decided in the descriptor
// state and its result beat registered; a successful byte read first adds the
// ring memory read. A new item is taken only once the last one is through, and a
// result beat that is still stalled when the next result is ready holds the input.
// Reset: rst_n async low clears in-use flags and control; memories are not cleared.
// Depends on mptf_pkg, mptf_alloc and mptf_ring.
module multi_pipe_ring_fifo_table
    import mptf_pkg::*;
#(
    parameter int NUM_PIPES  = NUM_PIPES_DEF,
    parameter int PIPE_DEPTH = PIPE_DEPTH_DEF,
    parameter int NUM_TASKS  = NUM_TASKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pipe_id[2:0], writer_task[6:3], reader_task[10:7], writer_exists[11],
    // reader_exists[12], current_task[16:13], data_in[24:17], zero[31:25]
    input  logic [31:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], pipe_out[5:2], data_out[13:6], wake_valid[14],
    // wake_task[18:15], zero[23:19]
    output logic [23:0] m_tdata
);

    localparam int PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W  = $clog2(PIPE_DEPTH);
    localparam int CNT_W  = $clog2(PIPE_DEPTH + 1);
    localparam logic [POUT_W-1:0] PIPE_NONE = POUT_W'(NUM_PIPES);

    typedef struct packed {
        logic [TASK_W-1:0] owner_w;
        logic [TASK_W-1:0] owner_r;
        logic              rsleep;
        logic              wsleep;
        logic [PTR_W-1:0]  rp;
        logic [PTR_W-1:0]  wp;
        logic [CNT_W-1:0]  fill;
    } desc_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DESC,
        S_RING,
        S_HOLD
    } state_t;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    kind_t             kind_reg, kind_next;
    res_t              out_reg, out_next;
    res_t              hold_reg, hold_next;
    logic              out_valid_reg, out_valid_next;
    logic              wake_v_reg, wake_v_next;
    logic [TASK_W-1:0] wake_t_reg, wake_t_next;

    item_t             in_item;
    logic              accept;
    logic              out_free;

    desc_t             desc_mem [NUM_PIPES];
    desc_t             desc_rd_reg;
    desc_t             desc_wdata;
    logic              desc_we;
    logic [PIPE_W-1:0] desc_waddr;
    logic [PIPE_W-1:0] desc_raddr;

    logic [PIPE_W-1:0] pid_idx;
    logic              pid_ok;
    logic              in_pid_range;
    logic              reg_pid_range;

    alloc_cmd_t           cmd;
    logic                 open_ok;
    logic [PIPE_W-1:0]    grant_idx;
    logic [NUM_PIPES-1:0] in_use;

    logic              ring_rd;
    logic              ring_wr;
    logic [PTR_W-1:0]  ring_ptr;
    logic [BYTE_W-1:0] ring_rdata;

    logic              fin;
    logic              to_ring;
    res_t              fin_res;

    assign in_item  = item_t'(s_tdata[$bits(item_t)-1:0]);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(24 - $bits(res_t))'(0), out_reg};

    // Clamp pipe numbers to a legal table index
    assign in_pid_range  = 32'(in_item.pipe_id) < NUM_PIPES;
    assign reg_pid_range = 32'(item_reg.pipe_id) < NUM_PIPES;
    assign desc_raddr    = in_pid_range ? PIPE_W'(in_item.pipe_id) : '0;
    assign pid_idx       = reg_pid_range ? PIPE_W'(item_reg.pipe_id) : '0;
    assign pid_ok        = reg_pid_range && in_use[pid_idx];

    // Descriptor memory: read at accept, write back during the descriptor cycle
    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[desc_waddr] <= desc_wdata;
        end
        if (accept)
        begin
            desc_rd_reg <= desc_mem[desc_raddr];
        end
    end

    mptf_alloc #(
        .NUM_PIPES (NUM_PIPES),
        .NUM_TASKS (NUM_TASKS),
        .PIPE_W    (PIPE_W)
    ) u_alloc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .close_idx (pid_idx),
        .open_ok   (open_ok),
        .grant_idx (grant_idx),
        .in_use    (in_use)
    );

    mptf_ring #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH),
        .PIPE_W     (PIPE_W),
        .PTR_W      (PTR_W)
    ) u_ring (
        .clk   (clk),
        .rd_en (ring_rd),
        .wr_en (ring_wr),
        .pipe  (pid_idx),
        .ptr   (ring_ptr),
        .wdata (item_reg.data_in),
        .rdata (ring_rdata)
    );

    // Decide the command, update descriptor, ring and allocation table
    always_comb
    begin
        desc_we     = 1'b0;
        desc_waddr  = pid_idx;
        desc_wdata  = desc_rd_reg;
        ring_rd     = 1'b0;
        ring_wr     = 1'b0;
        ring_ptr    = desc_rd_reg.rp;
        cmd               = '0;
        cmd.writer_task   = item_reg.writer_task;
        cmd.reader_task   = item_reg.reader_task;
        cmd.writer_exists = item_reg.writer_exists;
        cmd.reader_exists = item_reg.reader_exists;
        fin         = 1'b0;
        to_ring     = 1'b0;
        fin_res     = make_res(STAT_IGNORED, PIPE_NONE, '0, 1'b0, '0);
        wake_v_next = wake_v_reg;
        wake_t_next = wake_t_reg;

        if (state_reg == S_DESC)
        begin
            fin = 1'b1;
            unique case (kind_reg)
                KIND_OPEN:
                begin
                    cmd.open_en = 1'b1;
                    if (open_ok)
                    begin
                        desc_we            = 1'b1;
                        desc_waddr         = grant_idx;
                        desc_wdata         = '0;
                        desc_wdata.owner_w = item_reg.writer_task;
                        desc_wdata.owner_r = item_reg.reader_task;
                        fin_res = make_res(STAT_DONE, POUT_W'(grant_idx), '0, 1'b0, '0);
                    end
                    else
                    begin
                        fin_res = make_res(STAT_REFUSED, PIPE_NONE, '0, 1'b0, '0);
                    end
                end
                KIND_CLOSE:
                begin
                    if (pid_ok)
                    begin
                        cmd.close_en = 1'b1;
                        fin_res = make_res(STAT_DONE, PIPE_NONE, '0, 1'b0, '0);
                    end
                end
                KIND_READ:
                begin
                    if (pid_ok && desc_rd_reg.owner_r == item_reg.current_task)
                    begin
                        desc_we = 1'b1;
                        if (desc_rd_reg.fill == '0)
                        begin
                            desc_wdata.rsleep = 1'b1;
                            fin_res = make_res(STAT_BLOCK, PIPE_NONE, '0, 1'b0, '0);
                        end
                        else
                        begin
                            // Pop one byte; result waits for the ring read
                            ring_rd           = 1'b1;
                            desc_wdata.rp     = (desc_rd_reg.rp == PTR_W'(PIPE_DEPTH - 1))
                                                ? '0 : desc_rd_reg.rp + PTR_W'(1);
                            desc_wdata.fill   = desc_rd_reg.fill - CNT_W'(1);
                            desc_wdata.wsleep = 1'b0;
                            wake_v_next       = desc_rd_reg.wsleep;
                            wake_t_next       = desc_rd_reg.owner_w;
                            fin               = 1'b0;
                            to_ring           = 1'b1;
                        end
                    end
                end
                KIND_WRITE:
                begin
                    if (pid_ok && desc_rd_reg.owner_w == item_reg.current_task)
                    begin
                        desc_we = 1'b1;
                        if (desc_rd_reg.fill >= CNT_W'(PIPE_DEPTH))
                        begin
                            desc_wdata.wsleep = 1'b1;
                            fin_res = make_res(STAT_BLOCK, PIPE_NONE, '0, 1'b0, '0);
                        end
                        else
                        begin
                            // Push one byte and wake a sleeping reader
                            ring_wr           = 1'b1;
                            ring_ptr          = desc_rd_reg.wp;
                            desc_wdata.wp     = (desc_rd_reg.wp == PTR_W'(PIPE_DEPTH - 1))
                                                ? '0 : desc_rd_reg.wp + PTR_W'(1);
                            desc_wdata.fill   = desc_rd_reg.fill + CNT_W'(1);
                            desc_wdata.rsleep = 1'b0;
                            fin_res = make_res(STAT_DONE, PIPE_NONE, '0,
                                               desc_rd_reg.rsleep, desc_rd_reg.owner_r);
                        end
                    end
                end
                default:
                begin
                    fin_res = make_res(STAT_IGNORED, PIPE_NONE, '0, 1'b0, '0);
                end
            endcase
        end
        else if (state_reg == S_RING)
        begin
            fin     = 1'b1;
            fin_res = make_res(STAT_DONE, PIPE_NONE, ring_rdata, wake_v_reg, wake_t_reg);
        end
    end

    // Sequence the item and stage the result beat
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        kind_next      = kind_reg;
        out_next       = out_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = in_item;
                    kind_next  = kind_t'(s_tuser);
                    state_next = S_DESC;
                end
            end
            S_DESC, S_RING:
            begin
                if (to_ring)
                begin
                    state_next = S_RING;
                end
                else if (fin && out_free)
                begin
                    out_next       = fin_res;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (fin)
                begin
                    hold_next  = fin_res;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            kind_reg      <= KIND_OPEN;
            out_reg       <= '0;
            hold_reg      <= '0;
            wake_v_reg    <= 1'b0;
            wake_t_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            item_reg      <= item_next;
            kind_reg      <= kind_next;
            out_reg       <= out_next;
            hold_reg      <= hold_next;
            wake_v_reg    <= wake_v_next;
            wake_t_reg    <= wake_t_next;
        end
    end

    // A ring read result only follows a descriptor cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RING |-> $past(state_reg) == S_DESC)
        else $error("ring cycle without descriptor cycle");

    // A parked result only exists behind a stalled output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HOLD |-> out_valid_reg)
        else $error("held result with empty output register");

    // Wake requests only come with a completed byte move
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.wake_valid |-> out_reg.status == STAT_DONE)
        else $error("wake request on a failed item");

    // Fill count never runs past the pipe depth
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_we |-> desc_wdata.fill <= CNT_W'(PIPE_DEPTH))
        else $error("fill count overflow");

endmodule
